[hw/rtl/rbm_pkg.sv]
// Shared types and constants for the RSA block modular exponentiation engine.
`timescale 1ns / 1ps

package rbm_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } rbm_state_e;

endpackage

[hw/rtl/rbm_if.sv]
// Handshake channel interfaces: block input, result output and register writes.
`timescale 1ns / 1ps

interface rbm_in_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] block_value;

  modport source (output valid, output block_value, input ready);
  modport sink   (input valid, input block_value, output ready);
endinterface

interface rbm_out_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] result_value;

  modport source (output valid, output result_value, input ready);
  modport sink   (input valid, input result_value, output ready);
endinterface

interface rbm_cfg_if #(
  parameter int WORD_BITS = 32
);
  import rbm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [WORD_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/rsa_block_modexp.sv]
// Top level: RSA block modular exponentiation by square-and-multiply.
// Each block takes one reduction, one squaring per exponent bit and one multiply per set exponent bit,
// all run in turn on the one bit-serial modular multiplier.
// A new block is accepted only while the sequencer is idle, so blocks are processed one at a time.
// Modulus zero or exponent zero: the multiplier is skipped and the result is 0 or 1 respectively.
// Reset: sequencer idle, output empty, modulus and exponent both 1.
`timescale 1ns / 1ps

module rsa_block_modexp #(
  parameter int WORD_BITS = rbm_pkg::WORD_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rbm_cfg_if.sink  cfg_if,
  rbm_in_if.sink   in_if,
  rbm_out_if.source out_if
);
  import rbm_pkg::*;

  localparam int CW = $clog2(WORD_BITS);

  rbm_state_e state_q, state_d;

  logic [WORD_BITS-1:0] modulus_q;
  logic [WORD_BITS-1:0] exponent_q;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [WORD_BITS-1:0] base_q, base_d;
  logic [CW-1:0]        bit_q, bit_d;
  logic                 out_valid_q;
  logic [WORD_BITS-1:0] out_data_q;
  logic                 out_load;

  logic                 mm_start;
  logic [WORD_BITS-1:0] mm_a;
  logic [WORD_BITS-1:0] mm_b;
  logic                 mm_done;
  logic [WORD_BITS-1:0] mm_res;
  logic [WORD_BITS-1:0] acc_init;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= WORD_BITS'(1);
      exponent_q <= WORD_BITS'(1);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_MODULUS:  modulus_q  <= cfg_if.data;
        REG_EXPONENT: exponent_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  rbm_modmul #(
    .WORD_BITS(WORD_BITS)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .m_i    (modulus_q),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  assign in_if.ready = (state_q == ST_IDLE);
  assign acc_init    = (modulus_q == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    base_d   = base_q;
    bit_d    = bit_q;
    mm_start = 1'b0;
    mm_a     = '0;
    mm_b     = '0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          if (modulus_q == '0) begin
            acc_d   = '0;
            state_d = ST_FINISH;
          end else if (exponent_q == '0) begin
            acc_d   = WORD_BITS'(1);
            state_d = ST_FINISH;
          end else begin
            mm_start = 1'b1;
            mm_a     = WORD_BITS'(1);
            mm_b     = in_if.block_value;
            state_d  = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          base_d   = mm_res;
          acc_d    = acc_init;
          bit_d    = CW'(WORD_BITS - 1);
          mm_start = 1'b1;
          mm_a     = acc_init;
          mm_b     = acc_init;
          state_d  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mm_done) begin
          acc_d = mm_res;
          if (exponent_q[bit_q]) begin
            mm_start = 1'b1;
            mm_a     = mm_res;
            mm_b     = base_q;
            state_d  = ST_MULT;
          end else if (bit_q == '0) begin
            state_d = ST_FINISH;
          end else begin
            bit_d    = bit_q - CW'(1);
            mm_start = 1'b1;
            mm_a     = mm_res;
            mm_b     = mm_res;
          end
        end
      end
      ST_MULT: begin
        if (mm_done) begin
          acc_d = mm_res;
          if (bit_q == '0) begin
            state_d = ST_FINISH;
          end else begin
            bit_d    = bit_q - CW'(1);
            mm_start = 1'b1;
            mm_a     = mm_res;
            mm_b     = mm_res;
            state_d  = ST_SQUARE;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    bit_q  <= bit_d;
    if (out_load) begin
      out_data_q <= (acc_q == '0) ? modulus_q : acc_q;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.result_value = out_data_q;

endmodule

[hw/rtl/rbm_modmul.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle, double-and-add with reduction.
`timescale 1ns / 1ps

module rbm_modmul #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  input  logic [WORD_BITS-1:0] m_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] res_o
);

  localparam int CW = $clog2(WORD_BITS);
  localparam int TW = WORD_BITS + 3;

  logic                 busy_q;
  logic [CW-1:0]        cnt_q;
  logic [WORD_BITS-1:0] acc_q;
  logic [WORD_BITS-1:0] a_q;
  logic [WORD_BITS-1:0] b_q;
  logic [WORD_BITS-1:0] m_q;

  logic [TW-1:0] sum;
  logic [TW-1:0] diff1;
  logic [TW-1:0] diff2;
  logic [WORD_BITS-1:0] step;

  always_comb begin
    sum   = {2'b00, acc_q, 1'b0} + (b_q[WORD_BITS-1] ? {3'b000, a_q} : '0);
    diff1 = sum - {3'b000, m_q};
    diff2 = sum - {2'b00, m_q, 1'b0};
    priority if (!diff2[TW-1]) begin
      step = diff2[WORD_BITS-1:0];
    end else if (!diff1[TW-1]) begin
      step = diff1[WORD_BITS-1:0];
    end else begin
      step = sum[WORD_BITS-1:0];
    end
  end

  assign done_o = busy_q && (cnt_q == CW'(WORD_BITS - 1));
  assign res_o  = step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
    end else if (busy_q) begin
      acc_q <= step;
      b_q   <= {b_q[WORD_BITS-2:0], 1'b0};
    end
  end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the RSA block modular exponentiation engine.
`timescale 1ns / 1ps

module tb_top;
  import rbm_pkg::*;

  localparam int W            = WORD_BITS_DEF;
  localparam int HOLD_CYCLES  = 6000;
  localparam int IDLE_LIMIT   = 50000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_BLOCKS = 31;
  localparam int PRESSURE_PH  = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = REG_EXPONENT + 1'b1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = '1;

  logic clk_i = 1'b0;
  logic rst_ni;

  rbm_cfg_if #(.WORD_BITS(W)) cfg_bus ();
  rbm_in_if  #(.WORD_BITS(W)) in_bus ();
  rbm_out_if #(.WORD_BITS(W)) out_bus ();

  rsa_block_modexp #(.WORD_BITS(W)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_bus),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [W-1:0] blocks_to_send[$];
  logic [W-1:0] expected_results[$];
  logic [W-1:0] cur_modulus  = 1;
  logic [W-1:0] cur_exponent = 1;
  int           cfg_beats    = 0;
  int           fail_count   = 0;
  int           idle_cycles  = 0;
  logic         in_taken     = 1'b0;
  bit           no_idle      = 1'b0;
  bit           long_hold    = 1'b0;
  bit           hold_done    = 1'b0;
  int           send_gap     = 0;
  int           recv_gap     = 0;
  int           hold_left    = 0;

  function automatic logic [W-1:0] modexp_expect(input logic [W-1:0] blk,
                                                 input logic [W-1:0] m,
                                                 input logic [W-1:0] e);
    longint unsigned mm;
    longint unsigned base;
    longint unsigned acc;
    if (m == 0) return '0;
    if (e == 0) return 1;
    mm   = m;
    base = blk % mm;
    acc  = 1 % mm;
    for (int i = W - 1; i >= 0; i--) begin
      acc = (acc * acc) % mm;
      if (e[i]) acc = (acc * base) % mm;
    end
    if (acc == 0) acc = mm;
    return acc[W-1:0];
  endfunction

  function automatic int next_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 150);
  endfunction

  // input beats, register writes and result checks
  always @(posedge clk_i) begin
    logic [W-1:0] want;
    in_taken <= in_bus.valid && in_bus.ready;
    if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_bus.index)
        REG_MODULUS:  cur_modulus  <= cfg_bus.data;
        REG_EXPONENT: cur_exponent <= cfg_bus.data;
        default: ;
      endcase
      cfg_beats <= cfg_beats + 1;
    end
    if (in_bus.valid && in_bus.ready) begin
      expected_results.push_back(modexp_expect(in_bus.block_value, cur_modulus, cur_exponent));
    end
    if (out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("result_value: no beat expected, got %0d", out_bus.result_value);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_bus.result_value !== want) begin
          $error("result_value: expected %0d, got %0d", want, out_bus.result_value);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (blocks_to_send.size() != 0) begin
        in_bus.valid       <= 1'b1;
        in_bus.block_value <= blocks_to_send.pop_front();
        send_gap = next_gap();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (long_hold && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      recv_gap = next_gap();
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [W-1:0] value);
    int seen;
    seen = cfg_beats;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(negedge clk_i); while (cfg_beats == seen);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (blocks_to_send.size() != 0 || in_bus.valid || expected_results.size() != 0);
  endtask

  initial begin
    logic [W-1:0] mod;
    logic [W-1:0] expo;
    logic [W-1:0] blk;
    int           r;
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.block_value = '0;
    out_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_MODULUS;
    cfg_bus.data       = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    blocks_to_send.push_back('0);
    blocks_to_send.push_back('1);
    blocks_to_send.push_back(32'd12345);
    wait_drained();

    write_reg(REG_MODULUS, 32'd3233);
    write_reg(REG_EXPONENT, 32'd17);
    blocks_to_send.push_back(32'd65);
    blocks_to_send.push_back('0);
    blocks_to_send.push_back(32'd3232);
    blocks_to_send.push_back(32'd3233);
    blocks_to_send.push_back(32'd3234);
    blocks_to_send.push_back('1);
    wait_drained();

    write_reg(REG_EXPONENT, 32'd2753);
    blocks_to_send.push_back(32'd2790);
    blocks_to_send.push_back(32'd3233);
    wait_drained();

    write_reg(REG_EXPONENT, '0);
    blocks_to_send.push_back('0);
    blocks_to_send.push_back('1);
    wait_drained();

    write_reg(REG_MODULUS, '0);
    write_reg(REG_EXPONENT, 32'd5);
    blocks_to_send.push_back('0);
    blocks_to_send.push_back(32'd99);
    blocks_to_send.push_back('1);
    wait_drained();

    write_reg(REG_MODULUS, '1);
    write_reg(REG_EXPONENT, '1);
    blocks_to_send.push_back('1);
    blocks_to_send.push_back(32'hFFFF_FFFE);
    blocks_to_send.push_back(32'd2);
    blocks_to_send.push_back(32'd1);
    wait_drained();

    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    blocks_to_send.push_back(32'd3);
    blocks_to_send.push_back(32'h8000_0000);
    wait_drained();

    write_reg(REG_MODULUS, 32'd2_500_000_000);
    write_reg(REG_EXPONENT, 32'd65537);
    blocks_to_send.push_back(32'd2_499_999_999);
    blocks_to_send.push_back(32'd123456789);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      r = $urandom_range(0, 9);
      if (r == 0) mod = $urandom_range(0, 1);
      else if (r == 1) mod = $urandom_range(2, 1000);
      else if (r == 2) mod = '1;
      else if (r < 6) mod = $urandom();
      else mod = $urandom_range(2, 32'd2_500_000_000);
      r = $urandom_range(0, 9);
      if (r == 0) expo = '0;
      else if (r == 1) expo = 32'd65537;
      else if (r == 2) expo = '1;
      else if (r == 3) expo = 32'd3;
      else expo = $urandom();
      if (ph == PRESSURE_PH) begin
        mod  = $urandom_range(1000, 32'd2_500_000_000);
        expo = 32'd65537;
      end
      if ($urandom_range(0, 1) != 0) begin
        write_reg(REG_MODULUS, mod);
        write_reg(REG_EXPONENT, expo);
      end else begin
        write_reg(REG_EXPONENT, expo);
        write_reg(REG_MODULUS, mod);
      end
      no_idle = (ph % 4 == 3);
      if (ph == PRESSURE_PH) long_hold = 1'b1;
      for (int k = 0; k < PHASE_BLOCKS; k++) begin
        r = $urandom_range(0, 9);
        if (r == 0) blk = '0;
        else if (r == 1) blk = '1;
        else if (r == 2) blk = mod;
        else if (r == 3) blk = mod - 1'b1;
        else if (r == 4 || mod == 0) blk = $urandom();
        else blk = $urandom() % mod;
        blocks_to_send.push_back(blk);
      end
      wait_drained();
    end

    no_idle = 1'b0;
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/rbm_pkg.sv
hw/rtl/rbm_if.sv
hw/rtl/rbm_modmul.sv
hw/rtl/rsa_block_modexp.sv
tb/tb_top.sv
